// ===== rtl/core/mkdel_pkg.sv =====
// ----------------------------------------------------------------------------
// mkdel_pkg
// Types and constants shared by the key debouncer and event mailbox.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mkdel_pkg;

  localparam int NUM_KEYS         = 3;
  localparam int KEY_IDX_WIDTH    = 2;
  localparam int TICKS_WIDTH      = 16;
  localparam int CFG_INDEX_WIDTH  = 2;
  localparam logic [TICKS_WIDTH-1:0] DEFAULT_DEBOUNCE = 16'd15;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVE_LOW_MASK = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TICKS  = 2'd1;

  localparam logic EVENT_PRESS   = 1'b0;
  localparam logic EVENT_RELEASE = 1'b1;

  typedef struct packed {
    logic [NUM_KEYS-1:0] pin_levels;
    logic                read_event;
    logic                flush_events;
  } mkdel_in_t;

  typedef struct packed {
    logic                     event_pending;
    logic [KEY_IDX_WIDTH-1:0] event_key;
    logic                     event_kind;
    logic                     read_taken;
  } mkdel_out_t;

  // Per-tick control shared by all lanes.
  typedef struct packed {
    logic step;
    logic first;
  } mkdel_lane_ctl_t;

  // What one lane found on this tick.
  typedef struct packed {
    logic fire;
    logic kind;
  } mkdel_lane_evt_t;

endpackage

// ===== rtl/core/mkdel_lane.sv =====
// ----------------------------------------------------------------------------
// mkdel_lane
// Debounce lane for one key: edge detect, restart countdown, pressed state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mkdel_lane #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mkdel_pkg::mkdel_lane_ctl_t ctl,
  input  logic                       pin,
  input  logic                       corrected,
  input  logic [COUNT_WIDTH-1:0]     load,
  output mkdel_pkg::mkdel_lane_evt_t evt
);
  import mkdel_pkg::*;

  logic                   previous_level;
  logic                   pressed;
  logic                   running;
  logic [COUNT_WIDTH-1:0] countdown;
  logic                   edge_seen;
  logic                   expire;

  assign edge_seen = pin ^ previous_level;
  // The countdown reaches zero on this tick when it holds one.
  assign expire    = !ctl.first && !edge_seen && running &&
                     (countdown == COUNT_WIDTH'(1));

  assign evt.fire = expire && (corrected != pressed);
  assign evt.kind = corrected ? EVENT_PRESS : EVENT_RELEASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      pressed        <= 1'b0;
      running        <= 1'b0;
      countdown      <= '0;
    end else if (ctl.step) begin
      previous_level <= pin;
      if (ctl.first) begin
        pressed <= corrected;
      end else if (edge_seen) begin
        countdown <= load;
        running   <= 1'b1;
      end else if (running) begin
        countdown <= countdown - COUNT_WIDTH'(1);
        if (expire) begin
          running <= 1'b0;
          pressed <= corrected;
        end
      end
    end
  end

endmodule

// ===== rtl/core/mkdel_merge.sv =====
// ----------------------------------------------------------------------------
// mkdel_merge
// Combines lane events into the one-entry mailbox and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mkdel_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       read_event,
  input  logic                       flush_events,
  input  mkdel_pkg::mkdel_lane_evt_t lane_evt [mkdel_pkg::NUM_KEYS],
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mkdel_pkg::mkdel_out_t      out_data
);
  import mkdel_pkg::*;

  logic                     mailbox_full;
  logic [KEY_IDX_WIDTH-1:0] mailbox_key;
  logic                     mailbox_kind;
  logic                     any_fire;
  logic [KEY_IDX_WIDTH-1:0] sel_key;
  logic                     sel_kind;
  mkdel_out_t               result;

  // Later keys override earlier ones, so the highest-numbered firing key wins.
  always_comb begin
    any_fire = 1'b0;
    sel_key  = '0;
    sel_kind = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (lane_evt[i].fire) begin
        any_fire = 1'b1;
        sel_key  = KEY_IDX_WIDTH'(i);
        sel_kind = lane_evt[i].kind;
      end
    end
  end

  always_comb begin
    result.event_pending = mailbox_full;
    result.event_key     = mailbox_full ? mailbox_key : '0;
    result.event_kind    = mailbox_full ? mailbox_kind : 1'b0;
    result.read_taken    = read_event && mailbox_full;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mailbox_full <= 1'b0;
      mailbox_key  <= '0;
      mailbox_kind <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        out_data  <= result;
        out_valid <= 1'b1;
        // An event that expires on this tick survives a read or flush.
        if (any_fire) begin
          mailbox_full <= 1'b1;
          mailbox_key  <= sel_key;
          mailbox_kind <= sel_kind;
        end else if (read_event || flush_events) begin
          mailbox_full <= 1'b0;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/multi_key_debounce_event_latch.sv =====
// ----------------------------------------------------------------------------
// multi_key_debounce_event_latch
// The result is registered in the cycle after the input transfer is accepted.
// Throughput: one item per cycle unless out_ready stalls; lanes step on accept.
// Reset: synchronous; clears mailbox, countdowns and output valid, restores
// default configuration, and arms the first-tick load of the pressed states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_key_debounce_event_latch #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  mkdel_pkg::mkdel_in_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output mkdel_pkg::mkdel_out_t                 out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mkdel_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mkdel_pkg::TICKS_WIDTH-1:0]     cfg_data
);
  import mkdel_pkg::*;

  logic [NUM_KEYS-1:0]    active_low_mask;
  logic [TICKS_WIDTH-1:0] debounce_ticks;
  logic                   first_tick_pending;
  logic                   accept;
  logic [NUM_KEYS-1:0]    corrected;
  logic [31:0]            ticks_ext;
  logic [COUNT_WIDTH-1:0] load_raw;
  logic [COUNT_WIDTH-1:0] load;
  mkdel_lane_ctl_t        ctl;
  mkdel_lane_evt_t        lane_evt [NUM_KEYS];

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign corrected = in_data.pin_levels ^ active_low_mask;

  // A zero debounce count after width masking behaves as one tick.
  assign ticks_ext = 32'(debounce_ticks);
  assign load_raw  = ticks_ext[COUNT_WIDTH-1:0];
  assign load      = (load_raw == '0) ? COUNT_WIDTH'(1) : load_raw;

  assign ctl.step  = accept;
  assign ctl.first = first_tick_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low_mask    <= '0;
      debounce_ticks     <= DEFAULT_DEBOUNCE;
      first_tick_pending <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_ACTIVE_LOW_MASK: active_low_mask <= cfg_data[NUM_KEYS-1:0];
          REG_DEBOUNCE_TICKS:  debounce_ticks  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        first_tick_pending <= 1'b0;
      end
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    mkdel_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .pin       (in_data.pin_levels[k]),
      .corrected (corrected[k]),
      .load      (load),
      .evt       (lane_evt[k])
    );
  end

  mkdel_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .read_event   (in_data.read_event),
    .flush_events (in_data.flush_events),
    .lane_evt     (lane_evt),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

`ifndef SYNTH
  a_read_needs_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_taken |-> out_data.event_pending)
    else $error("read taken without a held event");

  a_key_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_pending |-> (out_data.event_key <= KEY_IDX_WIDTH'(NUM_KEYS - 1)))
    else $error("event key out of range");

  a_first_tick_once: assert property (@(posedge clk) disable iff (rst)
    accept |=> !first_tick_pending)
    else $error("first tick still pending after a transfer");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while the result register is stalled");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("transfer produced no result");
`endif

endmodule

// ===== dv/mkdel_debounce_checker.sv =====
// ----------------------------------------------------------------------------
// mkdel_debounce_checker
// Watches the input, result and register channels of the key debouncer. It
// keeps its own copy of the debounce state, predicts one result per accepted
// input transfer and compares every result transfer against the oldest
// prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mkdel_debounce_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  mkdel_pkg::mkdel_in_t                  in_data,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  mkdel_pkg::mkdel_out_t                 out_data,
  input  logic                                  cfg_valid,
  input  logic                                  cfg_ready,
  input  logic [mkdel_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mkdel_pkg::TICKS_WIDTH-1:0]     cfg_data,
  output int                                    fail_count,
  output int                                    pending_results
);
  import mkdel_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Register copies.
  logic [NUM_KEYS-1:0]    polarity_mask = '0;
  logic [TICKS_WIDTH-1:0] settle_ticks  = DEFAULT_DEBOUNCE;

  // Debounce state.
  logic [NUM_KEYS-1:0]    last_pins    = '0;
  logic [NUM_KEYS-1:0]    key_pressed  = '0;
  logic [NUM_KEYS-1:0]    timer_active = '0;
  logic [TICKS_WIDTH-1:0] settle_count [NUM_KEYS];
  logic                   awaiting_first = 1'b1;
  logic                   mbox_full = 1'b0;
  logic [KEY_IDX_WIDTH-1:0] mbox_key = '0;
  logic                   mbox_kind = 1'b0;

  mkdel_out_t expected_results [$];
  mkdel_out_t want;
  int         failures = 0;
  int         queued   = 0;

  assign fail_count      = failures;
  assign pending_results = queued;

  // One tick of the debouncer: reports the mailbox as it stood, then updates.
  function automatic mkdel_out_t debounce_tick(input mkdel_in_t t);
    mkdel_out_t             r;
    logic [NUM_KEYS-1:0]    level_now;
    logic [NUM_KEYS-1:0]    edges;
    logic [TICKS_WIDTH-1:0] reload;
    r.event_pending = mbox_full;
    r.event_key     = mbox_full ? mbox_key : '0;
    r.event_kind    = mbox_full ? mbox_kind : 1'b0;
    r.read_taken    = t.read_event && mbox_full;
    level_now = t.pin_levels ^ polarity_mask;
    reload    = (settle_ticks == '0) ? TICKS_WIDTH'(1) : settle_ticks;
    if (t.read_event || t.flush_events) mbox_full = 1'b0;
    if (awaiting_first) begin
      last_pins      = t.pin_levels;
      key_pressed    = level_now;
      awaiting_first = 1'b0;
      return r;
    end
    edges     = t.pin_levels ^ last_pins;
    last_pins = t.pin_levels;
    // Rising key order, so the highest key that expires this tick wins.
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (edges[k]) begin
        settle_count[k] = reload;
        timer_active[k] = 1'b1;
      end else if (timer_active[k]) begin
        settle_count[k] = settle_count[k] - TICKS_WIDTH'(1);
        if (settle_count[k] == '0) begin
          timer_active[k] = 1'b0;
          if (level_now[k] != key_pressed[k]) begin
            key_pressed[k] = level_now[k];
            mbox_full      = 1'b1;
            mbox_key       = KEY_IDX_WIDTH'(k);
            mbox_kind      = level_now[k] ? EVENT_PRESS : EVENT_RELEASE;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      polarity_mask  = '0;
      settle_ticks   = DEFAULT_DEBOUNCE;
      last_pins      = '0;
      key_pressed    = '0;
      timer_active   = '0;
      awaiting_first = 1'b1;
      mbox_full      = 1'b0;
      mbox_key       = '0;
      mbox_kind      = 1'b0;
      for (int k = 0; k < NUM_KEYS; k++) settle_count[k] = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (failures < REPORT_LIMIT)
            $display("%0t: result transfer with no prediction waiting", $realtime);
          failures <= failures + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data.event_pending !== want.event_pending ||
              out_data.event_key !== want.event_key ||
              out_data.event_kind !== want.event_kind ||
              out_data.read_taken !== want.read_taken) begin
            if (failures < REPORT_LIMIT)
              $display({"%0t: mismatch pending/key/kind/taken ",
                        "exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d"},
                       $realtime, want.event_pending, want.event_key, want.event_kind,
                       want.read_taken, out_data.event_pending, out_data.event_key,
                       out_data.event_kind, out_data.read_taken);
            failures <= failures + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ACTIVE_LOW_MASK: polarity_mask = cfg_data[NUM_KEYS-1:0];
          REG_DEBOUNCE_TICKS:  settle_ticks  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(debounce_tick(in_data));
    end
    queued <= expected_results.size();
  end

endmodule

// ===== dv/tb_multi_key_debounce_event_latch.sv =====
// ----------------------------------------------------------------------------
// tb_multi_key_debounce_event_latch
// Drives ticks of key pin levels with read and flush strobes into the
// debouncer under several polarity and debounce settings: a directed opening,
// then mostly stable pin runs with bounces and noise. Both channels idle at
// random; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_key_debounce_event_latch;
  import mkdel_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  mkdel_in_t                  in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  mkdel_out_t                 out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [TICKS_WIDTH-1:0]     cfg_data = '0;

  int fail_count;
  int pending_results;
  int cycle_count        = 0;
  int sender_idle_pct    = 7;
  int receiver_stall_pct = 78;
  int random_sent        = 0;
  int hold_left          = 0;
  logic [NUM_KEYS-1:0]    cur_pins  = '0;
  logic [TICKS_WIDTH-1:0] cur_ticks = DEFAULT_DEBOUNCE;

  always #5 clk = ~clk;

  multi_key_debounce_event_latch #(
    .COUNT_WIDTH(TICKS_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  mkdel_debounce_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_multi_key_debounce_event_latch NOT OK");
      $finish;
    end
  end

  task automatic push_tick(input mkdel_in_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_tick(input logic [NUM_KEYS-1:0] pins, input logic rd, input logic fl);
    mkdel_in_t t;
    t.pin_levels   = pins;
    t.read_event   = rd;
    t.flush_events = fl;
    push_tick(t);
  endtask

  // Drop valid and let every predicted result come out before touching registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_settings(input logic [NUM_KEYS-1:0] mask,
                                  input logic [TICKS_WIDTH-1:0] ticks);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ACTIVE_LOW_MASK;
    cfg_data  <= TICKS_WIDTH'(mask);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_DEBOUNCE_TICKS;
    cfg_data  <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_ticks = ticks;
  endtask

  // Mostly stable pin runs (expiring if debounce <= 64), short bounces, noise.
  function automatic mkdel_in_t make_random_tick();
    mkdel_in_t t;
    int        span;
    if (hold_left == 0) begin
      if ($urandom_range(99) < 20) begin
        cur_pins  = NUM_KEYS'($urandom);
        hold_left = $urandom_range(1, 2);
      end else begin
        cur_pins  = cur_pins ^ NUM_KEYS'($urandom_range(1, 7));
        span      = (cur_ticks == '0) ? 1 : int'(cur_ticks);
        hold_left = (span > 64) ? $urandom_range(1, 20) : span + $urandom_range(0, 4);
      end
    end
    hold_left--;
    t.pin_levels   = ($urandom_range(99) < 8) ? NUM_KEYS'($urandom) : cur_pins;
    t.read_event   = ($urandom_range(99) < 30);
    t.flush_events = ($urandom_range(99) < 6);
    return t;
  endfunction

  task automatic run_random(input int count, input logic [NUM_KEYS-1:0] mask,
                            input logic [TICKS_WIDTH-1:0] ticks);
    program_settings(mask, ticks);
    for (int n = 0; n < count; n++) begin
      if (random_sent < 550) begin
        sender_idle_pct    = 7;
        receiver_stall_pct = 78;
      end else if (random_sent < 1100) begin
        sender_idle_pct    = 78;
        receiver_stall_pct = 7;
      end else begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      push_tick(make_random_tick());
      random_sent++;
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Keys 0 and 2 active low, two-tick debounce.
    program_settings(3'b101, 16'd2);
    send_tick(3'b000, 1'b1, 1'b0);  // first tick loads states; read of empty mailbox
    send_tick(3'b111, 1'b0, 1'b0);  // edge on every key
    send_tick(3'b111, 1'b0, 1'b0);
    send_tick(3'b111, 1'b1, 1'b0);  // all three expire together; top key kept
    send_tick(3'b111, 1'b1, 1'b1);  // read and flush at once
    send_tick(3'b110, 1'b0, 1'b0);
    send_tick(3'b110, 1'b0, 1'b0);
    send_tick(3'b110, 1'b0, 1'b1);  // expiry in the flush tick survives it
    send_tick(3'b100, 1'b0, 1'b0);
    send_tick(3'b100, 1'b0, 1'b0);
    send_tick(3'b100, 1'b0, 1'b0);  // new event overwrites the held one
    send_tick(3'b000, 1'b1, 1'b0);
    send_tick(3'b000, 1'b0, 1'b0);
    send_tick(3'b000, 1'b1, 1'b0);  // expiry in the read tick survives it
    send_tick(3'b001, 1'b0, 1'b0);  // bounce restarts the countdown
    send_tick(3'b000, 1'b0, 1'b0);
    send_tick(3'b000, 1'b0, 1'b0);
    send_tick(3'b000, 1'b1, 1'b0);  // expires with no change of state
    send_tick(3'b000, 1'b0, 1'b1);
    send_tick(3'b000, 1'b1, 1'b1);
    wait_idle();

    run_random(400, 3'b000, 16'd1);
    run_random(350, 3'b111, 16'd0);  // zero debounce behaves as one
    run_random(400, NUM_KEYS'($urandom), TICKS_WIDTH'($urandom_range(3, 8)));
    run_random(40, 3'b010, 16'hFFFF);
    run_random(460, NUM_KEYS'($urandom), 16'd4);

    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_multi_key_debounce_event_latch OK");
    end else begin
      $display("tb_multi_key_debounce_event_latch NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mkdel_pkg.sv
rtl/core/mkdel_lane.sv
rtl/core/mkdel_merge.sv
rtl/core/multi_key_debounce_event_latch.sv
dv/mkdel_debounce_checker.sv
dv/tb_multi_key_debounce_event_latch.sv
